// File: sv/ent_pkg.sv
// Shared types, constants and helper functions of the expression number tokenizer.
`default_nettype none

package ent_pkg;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 48;
  localparam int MANT_W  = 64;
  localparam int FCNT_W  = 4;
  localparam int EXP_W   = 6;
  localparam int POW10_W = 30;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;
  localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [KIND_W-1:0] {
    TK_NUMBER = 3'd0,
    TK_ADD    = 3'd1,
    TK_MINUS  = 3'd2,
    TK_DIV    = 3'd3,
    TK_MUL    = 3'd4,
    TK_END    = 3'd5
  } token_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2,
    PH_EXP  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CT_ACCEPT   = 2'd0,
    CT_EVAL     = 2'd1,
    CT_EMIT_NUM = 2'd2,
    CT_EMIT_TOK = 2'd3
  } ctl_state_t;

  typedef enum logic [1:0] {
    EV_IDLE = 2'd0,
    EV_MUL  = 2'd1,
    EV_DIV  = 2'd2
  } ev_state_t;

  typedef struct packed {
    logic              start;
    logic              int_ovf;
    logic [FCNT_W-1:0] frac_cnt;
    logic [EXP_W-1:0]  exponent;
  } eval_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } eval_sts_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic token_kind_t op_kind(input logic [CHAR_W-1:0] c);
    token_kind_t k;
    case (c)
      CH_PLUS:  k = TK_ADD;
      CH_MINUS: k = TK_MINUS;
      CH_SLASH: k = TK_DIV;
      CH_STAR:  k = TK_MUL;
      default:  k = TK_END;
    endcase
    return k;
  endfunction

  function automatic logic [POW10_W-1:0] pow10(input logic [FCNT_W-1:0] k);
    logic [POW10_W-1:0] p;
    case (k)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: sv/ent_if.sv
// Valid/ready channel interfaces for characters in and tokens out.
`default_nettype none

interface ent_in_if;
  logic                       valid;
  logic                       ready;
  logic [ent_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ent_out_if;
  logic                        valid;
  logic                        ready;
  logic [ent_pkg::KIND_W-1:0]  token_kind;
  logic [ent_pkg::VALUE_W-1:0] number_value;
  logic                        saturated;
  logic                        last_of_item;

  modport source (output valid, output token_kind, output number_value,
                  output saturated, output last_of_item, input ready);
  modport sink   (input valid, input token_kind, input number_value,
                  input saturated, input last_of_item, output ready);
endinterface

`default_nettype wire

// File: sv/ent_eval.sv
// Iterative number evaluation unit: repeated times-ten scaling or bit-serial division.
`default_nettype none

module ent_eval #(
  parameter int INT_BITS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ent_pkg::eval_cmd_t          cmd,
  input  logic [ent_pkg::MANT_W-1:0]  mant,
  output ent_pkg::eval_sts_t          sts,
  output logic [ent_pkg::VALUE_W-1:0] value
);
  import ent_pkg::*;

  localparam int QW        = INT_BITS + FRAC_BITS;
  localparam int DIV_STEPS = MANT_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  ev_state_t            ev_r, ev_nxt;
  logic [MANT_W-1:0]    acc_r, acc_nxt;
  logic [POW10_W-1:0]   rem_r, rem_nxt;
  logic [POW10_W-1:0]   div_r, div_nxt;
  logic [QW-1:0]        q_r, q_nxt;
  logic                 qovf_r, qovf_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic                 sat_r, sat_nxt;
  logic [QW-1:0]        res_r, res_nxt;

  logic [POW10_W:0]     trial;
  logic                 ge;
  logic [POW10_W:0]     diff;
  logic [VALUE_W+QW-1:0] res_ext;

  // One restoring-division step: bring down the next dividend bit.
  assign trial = {rem_r, acc_r[MANT_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    ev_nxt   = ev_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    qovf_nxt = qovf_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    res_nxt  = res_r;
    case (ev_r)
      EV_IDLE: begin
        if (cmd.start) begin
          if (mant == '0) begin
            res_nxt  = '0;
            sat_nxt  = 1'b0;
            done_nxt = 1'b1;
          end else if (cmd.int_ovf) begin
            res_nxt  = '1;
            sat_nxt  = 1'b1;
            done_nxt = 1'b1;
          end else if ({{(EXP_W-FCNT_W){1'b0}}, cmd.frac_cnt} <= cmd.exponent) begin
            acc_nxt = mant;
            cnt_nxt = CNT_W'(cmd.exponent - {{(EXP_W-FCNT_W){1'b0}}, cmd.frac_cnt});
            ev_nxt  = EV_MUL;
          end else begin
            acc_nxt  = mant;
            div_nxt  = pow10(cmd.frac_cnt - cmd.exponent[FCNT_W-1:0]);
            rem_nxt  = '0;
            q_nxt    = '0;
            qovf_nxt = 1'b0;
            cnt_nxt  = CNT_W'(DIV_STEPS);
            ev_nxt   = EV_DIV;
          end
        end
      end
      EV_MUL: begin
        if (acc_r[MANT_W-1:INT_BITS] != '0) begin
          res_nxt  = '1;
          sat_nxt  = 1'b1;
          done_nxt = 1'b1;
          ev_nxt   = EV_IDLE;
        end else if (cnt_r == '0) begin
          res_nxt  = {acc_r[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
          sat_nxt  = 1'b0;
          done_nxt = 1'b1;
          ev_nxt   = EV_IDLE;
        end else begin
          acc_nxt = (acc_r << 3) + (acc_r << 1);
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      EV_DIV: begin
        rem_nxt  = ge ? diff[POW10_W-1:0] : trial[POW10_W-1:0];
        acc_nxt  = acc_r << 1;
        q_nxt    = {q_r[QW-2:0], ge};
        qovf_nxt = qovf_r | q_r[QW-1];
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          res_nxt  = qovf_nxt ? '1 : q_nxt;
          sat_nxt  = qovf_nxt;
          done_nxt = 1'b1;
          ev_nxt   = EV_IDLE;
        end
      end
      default: ev_nxt = EV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r   <= EV_IDLE;
      done_r <= 1'b0;
    end else begin
      ev_r   <= ev_nxt;
      done_r <= done_nxt;
    end
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    q_r    <= q_nxt;
    qovf_r <= qovf_nxt;
    cnt_r  <= cnt_nxt;
    sat_r  <= sat_nxt;
    res_r  <= res_nxt;
  end

  // The token field keeps the low bits of the fixed-point result.
  assign res_ext  = {{VALUE_W{1'b0}}, res_r};
  assign value    = res_ext[VALUE_W-1:0];
  assign sts.busy = (ev_r != EV_IDLE);
  assign sts.done = done_r;
  assign sts.sat  = sat_r;

endmodule

`default_nettype wire

// File: sv/expression_number_tokenizer.sv
// Top level of the expression number tokenizer: character scanner, control and token output.
//
// Usage: characters arrive one per request on in_ch (valid/ready); tokens leave on
// out_ch (valid/ready) with token_kind, number_value (unsigned fixed point with
// INT_BITS integer and FRAC_BITS fraction bits), saturated and last_of_item.
// A digit, dot or exponent letter that extends a number is taken and gives no
// token. An operator or other character from idle gives one token; once it is
// taken, its token is loaded into the output register as soon as the register is
// free, and no further character is taken until then.
// A character that ends a number gives two tokens: the number (last_of_item low)
// and then the token for that character (last_of_item high). The number is
// evaluated by a single iterative unit: a net exponent of zero or more is scaled
// by ten once per power of ten (stopping early when the value clamps), a fractional
// result goes through bit-serial division, and zero or integer overflow is
// answered without iteration.
// in_ch.ready is high only while no character is in progress. One token waits in
// the output register; when the receiver stalls, a following character is still
// taken and its token waits in the controller until the register frees.
// Reset (rst_n low, synchronous) returns the scanner to idle with no pending
// number and empties the output register.
`default_nettype none

module expression_number_tokenizer #(
  parameter int FRAC_BITS       = 16,
  parameter int INT_BITS        = 32,
  parameter int MAX_FRAC_DIGITS = 9,
  parameter int MAX_EXPONENT    = 63
) (
  input  logic      clk,
  input  logic      rst_n,
  ent_in_if.sink    in_ch,
  ent_out_if.source out_ch
);
  import ent_pkg::*;

  // Scanner state of the number under construction.
  phase_t              phase_r, phase_nxt;
  logic [MANT_W-1:0]   mant_r, mant_nxt;
  logic [FCNT_W-1:0]   fcnt_r, fcnt_nxt;
  logic [EXP_W-1:0]    exp_r, exp_nxt;
  logic                iovf_r, iovf_nxt;

  // Control and the character whose token is still owed.
  ctl_state_t          ctl_r, ctl_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  token_kind_t         out_kind_r, out_kind_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                out_sat_r, out_sat_nxt;
  logic                out_last_r, out_last_nxt;

  logic                accept;
  logic                out_free;
  logic                out_load;
  logic [CHAR_W-1:0]   c;
  logic                c_digit;
  logic [3:0]          d;
  logic                c_is_e;
  logic [MANT_W-1:0]   mant_times10;
  logic [EXP_W+3:0]    exp_times10;
  logic                terminate;

  eval_cmd_t           eval_cmd;
  eval_sts_t           eval_sts;
  logic [VALUE_W-1:0]  eval_value;

  assign c            = in_ch.char_code;
  assign c_digit      = is_digit(c);
  assign d            = c[3:0] - CH_ZERO[3:0];
  assign c_is_e       = (c == CH_E_LO) || (c == CH_E_UP);
  assign mant_times10 = (mant_r << 3) + (mant_r << 1) + MANT_W'(d);
  assign exp_times10  = ({4'b0, exp_r} << 3) + ({4'b0, exp_r} << 1) + (EXP_W+4)'(d);

  assign in_ch.ready = (ctl_r == CT_ACCEPT);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // A character that cannot continue the current number ends it.
  always_comb begin
    terminate = 1'b0;
    case (phase_r)
      PH_IDLE: terminate = 1'b0;
      PH_INT:  terminate = !c_digit && (c != CH_DOT) && !c_is_e;
      PH_FRAC: terminate = !c_digit && !c_is_e;
      PH_EXP:  terminate = !c_digit;
      default: terminate = 1'b0;
    endcase
  end

  // The evaluation unit samples the finished number in the cycle it is ended.
  assign eval_cmd.start    = accept && terminate;
  assign eval_cmd.int_ovf  = iovf_r;
  assign eval_cmd.frac_cnt = fcnt_r;
  assign eval_cmd.exponent = exp_r;

  ent_eval #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (eval_cmd),
    .mant  (mant_r),
    .sts   (eval_sts),
    .value (eval_value)
  );

  always_comb begin
    phase_nxt     = phase_r;
    mant_nxt      = mant_r;
    fcnt_nxt      = fcnt_r;
    exp_nxt       = exp_r;
    iovf_nxt      = iovf_r;
    ctl_nxt       = ctl_r;
    char_nxt      = char_r;
    out_load      = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_sat_nxt   = out_sat_r;
    out_last_nxt  = out_last_r;

    case (ctl_r)
      CT_ACCEPT: begin
        if (accept) begin
          if (terminate) begin
            // The number goes to the evaluator; the scanner is free again.
            phase_nxt = PH_IDLE;
            mant_nxt  = '0;
            fcnt_nxt  = '0;
            exp_nxt   = '0;
            iovf_nxt  = 1'b0;
            char_nxt  = c;
            ctl_nxt   = CT_EVAL;
          end else begin
            case (phase_r)
              PH_IDLE: begin
                if (c_digit) begin
                  phase_nxt = PH_INT;
                  mant_nxt  = MANT_W'(d);
                  fcnt_nxt  = '0;
                  exp_nxt   = '0;
                  iovf_nxt  = 1'b0;
                end else begin
                  char_nxt = c;
                  ctl_nxt  = CT_EMIT_TOK;
                end
              end
              PH_INT: begin
                if (c_digit) begin
                  // Once the integer part would reach the limit, further digits are dropped.
                  if (!iovf_r) begin
                    if (mant_times10[MANT_W-1:INT_BITS] != '0) begin
                      iovf_nxt = 1'b1;
                    end else begin
                      mant_nxt = mant_times10;
                    end
                  end
                end else if (c == CH_DOT) begin
                  phase_nxt = PH_FRAC;
                end else begin
                  phase_nxt = PH_EXP;
                end
              end
              PH_FRAC: begin
                if (c_digit) begin
                  // Fraction digits beyond the kept count are truncated.
                  if (fcnt_r < FCNT_W'(MAX_FRAC_DIGITS)) begin
                    mant_nxt = mant_times10;
                    fcnt_nxt = fcnt_r + 1'b1;
                  end
                end else begin
                  phase_nxt = PH_EXP;
                end
              end
              PH_EXP: begin
                if (exp_times10 > (EXP_W+4)'(MAX_EXPONENT)) begin
                  exp_nxt = EXP_W'(MAX_EXPONENT);
                end else begin
                  exp_nxt = exp_times10[EXP_W-1:0];
                end
              end
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
      end
      CT_EVAL: begin
        if (eval_sts.done) begin
          ctl_nxt = CT_EMIT_NUM;
        end
      end
      CT_EMIT_NUM: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = TK_NUMBER;
          out_value_nxt = eval_value;
          out_sat_nxt   = eval_sts.sat;
          out_last_nxt  = 1'b0;
          ctl_nxt       = CT_EMIT_TOK;
        end
      end
      CT_EMIT_TOK: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = op_kind(char_r);
          out_value_nxt = '0;
          out_sat_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          ctl_nxt       = CT_ACCEPT;
        end
      end
      default: ctl_nxt = CT_ACCEPT;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      mant_r      <= '0;
      fcnt_r      <= '0;
      exp_r       <= '0;
      iovf_r      <= 1'b0;
      ctl_r       <= CT_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      mant_r      <= mant_nxt;
      fcnt_r      <= fcnt_nxt;
      exp_r       <= exp_nxt;
      iovf_r      <= iovf_nxt;
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    char_r      <= char_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_sat_r   <= out_sat_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_kind   = out_kind_r;
  assign out_ch.number_value = out_value_r;
  assign out_ch.saturated    = out_sat_r;
  assign out_ch.last_of_item = out_last_r;

`ifndef ASSERT_OFF
  // The evaluator is only started when it has finished the previous number.
  a_eval_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    eval_cmd.start |-> !eval_sts.busy)
    else $error("evaluation started while busy");

  // A finished evaluation is only reported while the controller waits for it.
  a_eval_done_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    eval_sts.done |-> (ctl_r == CT_EVAL))
    else $error("evaluation result arrived outside the evaluation wait");

  // A waiting token must never overwrite one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !out_load)
    else $error("output register overwritten while stalled");

  // A loaded number token is always followed by the token of its ending character.
  a_number_then_token: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (out_kind_nxt == TK_NUMBER)) |=> (ctl_r == CT_EMIT_TOK))
    else $error("number token not followed by its ending token");

  // The integer overflow mark never survives the end of a number.
  a_ovf_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> !iovf_r)
    else $error("integer overflow mark left set while idle");
`endif

endmodule

`default_nettype wire

// File: tb/token_checker.sv
// Token checker: predicts the tokens of each accepted character and compares them on the output.
`timescale 1ns / 100ps

module token_checker #(
  parameter int FRAC_BITS       = 16,
  parameter int INT_BITS        = 32,
  parameter int MAX_FRAC_DIGITS = 9,
  parameter int MAX_EXPONENT    = 63
) (
  input  logic clk,
  input  logic rst_n,
  ent_in_if    in_ch,
  ent_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   tokens_checked,
  output int   numbers_checked,
  output int   saturated_seen
);
  import ent_pkg::*;

  typedef struct packed {
    token_kind_t        kind;
    logic [VALUE_W-1:0] value;
    logic               sat;
    logic               last;
  } token_t;

  token_t expected_tokens[$];

  // Scanner state of the predictor.
  phase_t             scan_phase;
  logic [MANT_W-1:0]  mant;
  logic [FCNT_W-1:0]  frac_digits;
  logic [EXP_W-1:0]   exp_acc;
  logic               int_ovf;

  task automatic report(input string msg);
    $display("[%0t] token %0d: %s", $time, tokens_checked, msg);
    fail_count++;
  endtask

  task automatic clear_number();
    mant        = '0;
    frac_digits = '0;
    exp_acc     = '0;
    int_ovf     = 1'b0;
  endtask

  task automatic push_token(input token_kind_t k, input logic [VALUE_W-1:0] v,
                            input logic s, input logic l);
    token_t t;
    t.kind  = k;
    t.value = v;
    t.sat   = s;
    t.last  = l;
    expected_tokens.push_back(t);
  endtask

  // Exact value floor(mant * 10^exp * 2^FRAC_BITS / 10^frac), clamped at full scale.
  function automatic logic [VALUE_W-1:0] fixed_value(output logic sat);
    logic [MANT_W-1:0] lim;
    logic [MANT_W-1:0] maxv;
    logic [MANT_W-1:0] q;
    logic [MANT_W-1:0] scale;
    logic [MANT_W-1:0] rem;
    logic [MANT_W-1:0] full;
    int                net;
    lim  = 64'd1 << INT_BITS;
    maxv = (64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1;
    sat  = 1'b0;
    if (mant == '0) return '0;
    if (int_ovf) begin
      sat = 1'b1;
      return maxv[VALUE_W-1:0];
    end
    net = int'(exp_acc) - int'(frac_digits);
    if (net >= 0) begin
      q = mant;
      if (q >= lim) begin
        sat = 1'b1;
        return maxv[VALUE_W-1:0];
      end
      for (int i = 0; i < net; i++) begin
        q = q * 64'd10;
        if (q >= lim) begin
          sat = 1'b1;
          return maxv[VALUE_W-1:0];
        end
      end
      full = q << FRAC_BITS;
      return full[VALUE_W-1:0];
    end
    scale = 64'd1;
    for (int i = 0; i < -net; i++) scale = scale * 64'd10;
    q   = mant / scale;
    rem = mant % scale;
    if (q >= lim) begin
      sat = 1'b1;
      return maxv[VALUE_W-1:0];
    end
    full = (q << FRAC_BITS) + ((rem << FRAC_BITS) / scale);
    return full[VALUE_W-1:0];
  endfunction

  task automatic start_from_idle(input logic [CHAR_W-1:0] c);
    token_kind_t k;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      clear_number();
      mant       = MANT_W'(c - CH_ZERO);
      scan_phase = PH_INT;
      return;
    end
    case (c)
      CH_PLUS:  k = TK_ADD;
      CH_MINUS: k = TK_MINUS;
      CH_SLASH: k = TK_DIV;
      CH_STAR:  k = TK_MUL;
      default:  k = TK_END;
    endcase
    push_token(k, '0, 1'b0, 1'b1);
  endtask

  task automatic scan_char(input logic [CHAR_W-1:0] c);
    logic               is_dig;
    logic               is_exp;
    logic [MANT_W-1:0]  d;
    logic [MANT_W-1:0]  grown;
    logic [VALUE_W-1:0] v;
    logic               s;
    int                 ne;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    is_exp = (c == CH_E_LO) || (c == CH_E_UP);
    d      = is_dig ? MANT_W'(c - CH_ZERO) : '0;
    case (scan_phase)
      PH_IDLE: begin
        start_from_idle(c);
        return;
      end
      PH_INT: begin
        if (is_dig) begin
          if (!int_ovf) begin
            grown = mant * 64'd10 + d;
            if (grown >= (64'd1 << INT_BITS)) int_ovf = 1'b1;
            else mant = grown;
          end
          return;
        end
        if (c == CH_DOT) begin
          scan_phase = PH_FRAC;
          return;
        end
        if (is_exp) begin
          scan_phase = PH_EXP;
          return;
        end
      end
      PH_FRAC: begin
        if (is_dig) begin
          if (frac_digits < MAX_FRAC_DIGITS) begin
            mant        = mant * 64'd10 + d;
            frac_digits = frac_digits + 1'b1;
          end
          return;
        end
        if (is_exp) begin
          scan_phase = PH_EXP;
          return;
        end
      end
      default: begin
        if (is_dig) begin
          ne      = int'(exp_acc) * 10 + int'(d);
          exp_acc = (ne > MAX_EXPONENT) ? EXP_W'(MAX_EXPONENT) : EXP_W'(ne);
          return;
        end
      end
    endcase
    // The character cannot continue the number: emit the number, then treat the character afresh.
    v = fixed_value(s);
    push_token(TK_NUMBER, v, s, 1'b0);
    scan_phase = PH_IDLE;
    clear_number();
    start_from_idle(c);
  endtask

  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      report($sformatf("token of kind %0d with none expected", out_ch.token_kind));
      return;
    end
    want = expected_tokens.pop_front();
    if (out_ch.token_kind !== want.kind)
      report($sformatf("kind %0d, expected %0d", out_ch.token_kind, want.kind));
    if (out_ch.number_value !== want.value)
      report($sformatf("value 0x%012h, expected 0x%012h", out_ch.number_value, want.value));
    if (out_ch.saturated !== want.sat)
      report($sformatf("saturated %0b, expected %0b", out_ch.saturated, want.sat));
    if (out_ch.last_of_item !== want.last)
      report($sformatf("last_of_item %0b, expected %0b", out_ch.last_of_item, want.last));
    tokens_checked++;
    if (want.kind == TK_NUMBER) numbers_checked++;
    if (want.sat) saturated_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scan_phase = PH_IDLE;
      clear_number();
      expected_tokens.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_token();
      if (in_ch.valid && in_ch.ready) scan_char(in_ch.char_code);
    end
    pending = expected_tokens.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the tokenizer testbench: clock, reset, character stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module testbench;
  import ent_pkg::*;

  localparam int FRAC_BITS       = 16;
  localparam int INT_BITS        = 32;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int MAX_EXPONENT    = 63;

  // Least number of random characters after the directed text.
  localparam int RANDOM_CHARS = 1950;
  // The longest number evaluation is a bit-serial divide, so this drain time after
  // the last token covers any straggler.
  localparam int DRAIN_CYCLES = 200;
  // The slowest correct run is roughly 2000 requests, each with two stalled tokens
  // and a full divide, plus the long hold-off; this limit is several times that.
  localparam int LIMIT_CYCLES = 1500000;
  // The long receiver hold-off starts after this many requests and lasts this long.
  localparam int HOLD_AFTER   = 800;
  localparam int HOLD_CYCLES  = 500;

  localparam logic [CHAR_W-1:0] OP_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR};
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_HIGH  = 8'hFF;

  // Ways the receiver throttles the output channel; one is picked per stretch.
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  logic clk;
  logic rst_n;
  logic long_hold = 1'b0;
  int   chars_sent;
  int   directed_count;
  int   cycle_count;

  int   fail_count;
  int   pending;
  int   tokens_checked;
  int   numbers_checked;
  int   saturated_seen;

  logic [CHAR_W-1:0] text_q[$];

  ent_in_if  in_ch();
  ent_out_if out_ch();

  expression_number_tokenizer #(
    .FRAC_BITS      (FRAC_BITS),
    .INT_BITS       (INT_BITS),
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
    .MAX_EXPONENT   (MAX_EXPONENT)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  token_checker #(
    .FRAC_BITS      (FRAC_BITS),
    .INT_BITS       (INT_BITS),
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
    .MAX_EXPONENT   (MAX_EXPONENT)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .tokens_checked (tokens_checked),
    .numbers_checked(numbers_checked),
    .saturated_seen (saturated_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake or a lost token ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("expression_number_tokenizer: mismatch");
      $finish;
    end
  end

  // Appends a literal string, one character per request.
  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Length of a digit run: mostly short, sometimes medium, and now and then long
  // enough to overflow the integer part or to run past the kept fraction digits.
  function automatic int digit_run_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 9);
    return $urandom_range(10, 12);
  endfunction

  task automatic queue_digits(input int n);
    for (int i = 0; i < n; i++) text_q.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  // A well-formed number with random content, closed by some character that may
  // or may not be able to continue it.
  task automatic queue_number();
    int r;
    queue_digits(digit_run_length());
    if ($urandom_range(0, 2) != 0) begin
      text_q.push_back(CH_DOT);
      // An empty fraction now and then.
      if ($urandom_range(0, 7) != 0) queue_digits(digit_run_length());
    end
    if ($urandom_range(0, 3) == 0) begin
      text_q.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
      // Zero exponent digits is the empty exponent; two digits can exceed the cap.
      queue_digits($urandom_range(0, 2));
    end
    r = $urandom_range(0, 15);
    if (r < 10)       text_q.push_back(OP_CHARS[$urandom_range(0, 3)]);
    else if (r == 10) text_q.push_back(CH_NUL);
    else if (r == 11) text_q.push_back(CHAR_W'($urandom_range(0, 255)));
    else if (r == 12) text_q.push_back(CH_DOT);
    else if (r == 13) text_q.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
    else if (r == 14) text_q.push_back(CH_HIGH);
    else              text_q.push_back(CH_SPACE);
  endtask

  // Offers one character and holds it until the block takes the request.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    do @(posedge clk); while (!in_ch.ready);
    chars_sent++;
  endtask

  // Receiver: picks a throttling mode for a stretch of cycles, and goes fully
  // quiet while the long hold-off is on.
  initial begin
    rx_mode_t          mode;
    logic [7:0]        mask;
    int                span;
    out_ch.ready <= 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      mask = 8'($urandom_range(1, 255));
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(posedge clk);
        if (long_hold) begin
          out_ch.ready <= 1'b0;
        end else begin
          case (mode)
            RX_OPEN:   out_ch.ready <= 1'b1;
            RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ch.ready <= ($urandom_range(0, 7) != 0);
            default: begin
              out_ch.ready <= mask[0];
              mask = {mask[0], mask[7:1]};
            end
          endcase
        end
      end
    end
  end

  // Long hold-off: the receiver stops while the sender keeps offering, so the
  // output register and the controller fill up and the block must stall its input.
  initial begin
    wait (chars_sent >= HOLD_AFTER);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    int burst;
    int gap;
    int r;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= '0;

    // Directed text: every operator, the extreme character codes, an exponent
    // letter from idle, then numbers for the special cases. The long fraction is
    // truncated and has an empty exponent; the dot after the exponent ends the
    // number and then gives End from idle. A huge exponent overflows the result,
    // while the same exponent on zero does not. Ten integer digits overflow the
    // integer part.
    queue_text("+-/*");
    text_q.push_back(CH_NUL);
    text_q.push_back(CH_HIGH);
    text_q.push_back(CH_E_LO);
    queue_text("0.1234567891E.");
    queue_text("9e99/");
    queue_text("0e99-");
    queue_text("4294967296+");
    directed_count = text_q.size();

    // Random text: mostly well-formed numbers, with lone operators, stray bytes
    // and runs of noise mixed in.
    while (text_q.size() < directed_count + RANDOM_CHARS) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        queue_number();
      end else if (r == 7) begin
        text_q.push_back(OP_CHARS[$urandom_range(0, 3)]);
      end else if (r == 8) begin
        text_q.push_back(CHAR_W'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) text_q.push_back(CHAR_W'($urandom_range(0, 255)));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Sender: bursts of requests with random gaps, and now and then a long burst
    // with no gap at all. During a gap the character lines carry junk.
    while (text_q.size() > 0) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
      while (burst > 0 && text_q.size() > 0) begin
        send_char(text_q.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid     <= 1'b0;
        in_ch.char_code <= CHAR_W'($urandom_range(0, 255));
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    // Let the checker see the last request before looking at what is still owed.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters (%0d directed), checked %0d tokens.",
             chars_sent, directed_count, tokens_checked);
    $display("Numbers checked: %0d, of which %0d clamped to full scale.",
             numbers_checked, saturated_seen);
    if (pending != 0) $display("%0d expected tokens never arrived.", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("expression_number_tokenizer: match");
    end else begin
      $display("expression_number_tokenizer: mismatch");
    end
    $finish;
  end

endmodule
